/* design/spm_pkg.sv */
`default_nettype none

package spm_pkg;

	// magnitude of a non-negative 12-bit coordinate
	localparam int unsigned REM_W = 11;
	// panel index along one axis, always below a 5-bit register value
	localparam int unsigned QUO_W = 5;
	localparam int unsigned ORDER_W = 10;

	typedef enum logic [1:0] {
		REG_PNL_W          = 2'd0,
		REG_PNL_H          = 2'd1,
		REG_PANEL_ROWS     = 2'd2,
		REG_PANELS_PER_ROW = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] pnl_w;
		logic [7:0] pnl_h;
		logic [4:0] panel_rows;
		logic [4:0] panels_per_row;
	} cfg_t;

	typedef struct packed {
		logic signed [11:0] pixel_x;
		logic signed [11:0] pixel_y;
		logic [7:0]         red_in;
		logic [7:0]         green_in;
		logic [7:0]         blue_in;
	} pixel_t;

	typedef struct packed {
		logic [14:0] chain_x;
		logic [6:0]  chain_y;
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
	} chain_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} colour_t;

endpackage

`default_nettype wire

/* design/spm_cfg.sv */
`default_nettype none

module spm_cfg (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output spm_pkg::cfg_t     cfg
);

	spm_pkg::cfg_t    cfg_q;
	spm_pkg::cfg_reg_t reg_sel;
	logic             wr_en;

	assign pready  = 1'b1;
	assign reg_sel = spm_pkg::cfg_reg_t'(paddr[3:2]);
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pnl_w          <= 8'd32;
			cfg_q.pnl_h          <= 8'd32;
			cfg_q.panel_rows     <= 5'd1;
			cfg_q.panels_per_row <= 5'd1;
		end else if (wr_en) begin
			unique case (reg_sel)
				spm_pkg::REG_PNL_W:          cfg_q.pnl_w          <= pwdata[7:0];
				spm_pkg::REG_PNL_H:          cfg_q.pnl_h          <= pwdata[7:0];
				spm_pkg::REG_PANEL_ROWS:     cfg_q.panel_rows     <= pwdata[4:0];
				spm_pkg::REG_PANELS_PER_ROW: cfg_q.panels_per_row <= pwdata[4:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			spm_pkg::REG_PNL_W:          prdata = {24'd0, cfg_q.pnl_w};
			spm_pkg::REG_PNL_H:          prdata = {24'd0, cfg_q.pnl_h};
			spm_pkg::REG_PANEL_ROWS:     prdata = {27'd0, cfg_q.panel_rows};
			spm_pkg::REG_PANELS_PER_ROW: prdata = {27'd0, cfg_q.panels_per_row};
		endcase
	end

endmodule

`default_nettype wire

/* design/spm_div_step.sv */
`default_nettype none

// one restoring division step: quotient bit BIT_POS
module spm_div_step #(
	parameter int unsigned BIT_POS = 0
) (
	input  wire logic [spm_pkg::REM_W-1:0] rem,
	input  wire logic [spm_pkg::QUO_W-1:0] quo,
	input  wire logic [7:0]                divisor,
	output logic [spm_pkg::REM_W-1:0]      rem_next,
	output logic [spm_pkg::QUO_W-1:0]      quo_next
);

	localparam int unsigned SH_W = 8 + spm_pkg::QUO_W - 1;

	logic [SH_W-1:0] shifted;
	logic            take;

	assign shifted  = SH_W'(divisor) << BIT_POS;
	assign take     = SH_W'(rem) >= shifted;
	// shifted fits the remainder width whenever take is set
	assign rem_next = take ? (rem - shifted[spm_pkg::REM_W-1:0]) : rem;
	assign quo_next = quo | (spm_pkg::QUO_W'(take) << BIT_POS);

endmodule

`default_nettype wire

/* design/serpentine_panel_pixel_mapper.sv */
// serpentine_panel_pixel_mapper: virtual canvas pixel to serpentine panel chain position
// five register stages from pixel transaction to chain transaction
// throughput: one pixel per cycle; each stage advances when it is empty or its successor moves
// off-canvas pixels are dropped in stage 1 and give no chain transaction
// reset: valid bits clear, registers return to 32x32 panels, one row of one panel
`default_nettype none

module serpentine_panel_pixel_mapper (
	input  wire logic           clk,
	input  wire logic           arst_n,
	// pixel channel
	input  wire logic           pixel_valid,
	output logic                pixel_stall,
	input  wire spm_pkg::pixel_t pixel,
	// chain channel
	output logic                chain_valid,
	input  wire logic           chain_stall,
	output spm_pkg::chain_t     chain,
	// register port
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [3:0]     paddr,
	input  wire logic [31:0]    pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int unsigned RW = spm_pkg::REM_W;
	localparam int unsigned QW = spm_pkg::QUO_W;
	localparam int unsigned OW = spm_pkg::ORDER_W;

	spm_pkg::cfg_t cfg;

	spm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// per-stage advance: a stage loads when it is empty or its content moves on
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;

	assign adv_s5 = !valid_s5 || !chain_stall;
	assign adv_s4 = !valid_s4 || adv_s5;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;

	assign pixel_stall = !adv_s1;

	// ---------------- stage 1: canvas bounds check ----------------
	// canvas size is at most 31 * 255, so 13 bits cover it
	logic [12:0] canvas_w, canvas_h;
	logic        on_canvas;

	assign canvas_w = 13'(cfg.panels_per_row * cfg.pnl_w);
	assign canvas_h = 13'(cfg.panel_rows * cfg.pnl_h);
	// a negative coordinate fails through its sign bit; a zero register gives an empty canvas
	assign on_canvas = !pixel.pixel_x[11] && !pixel.pixel_y[11]
		&& (13'(pixel.pixel_x[RW-1:0]) < canvas_w)
		&& (13'(pixel.pixel_y[RW-1:0]) < canvas_h);

	logic [RW-1:0]     x_s1, y_s1;
	spm_pkg::colour_t  col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= pixel_valid && on_canvas;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pixel_valid) begin
			x_s1         <= pixel.pixel_x[RW-1:0];
			y_s1         <= pixel.pixel_y[RW-1:0];
			col_s1.red   <= pixel.red_in;
			col_s1.green <= pixel.green_in;
			col_s1.blue  <= pixel.blue_in;
		end
	end

	// ---------------- stage 2: upper two quotient bits ----------------
	// the quotient is the panel index, below panels_per_row or panel_rows, so five bits do
	logic [RW-1:0] xr4, xr3, yr4, yr3;
	logic [QW-1:0] xq4, xq3, yq4, yq3;

	spm_div_step #(.BIT_POS(4)) u_x4 (
		.rem(x_s1), .quo('0), .divisor(cfg.pnl_w), .rem_next(xr4), .quo_next(xq4)
	);
	spm_div_step #(.BIT_POS(3)) u_x3 (
		.rem(xr4), .quo(xq4), .divisor(cfg.pnl_w), .rem_next(xr3), .quo_next(xq3)
	);
	spm_div_step #(.BIT_POS(4)) u_y4 (
		.rem(y_s1), .quo('0), .divisor(cfg.pnl_h), .rem_next(yr4), .quo_next(yq4)
	);
	spm_div_step #(.BIT_POS(3)) u_y3 (
		.rem(yr4), .quo(yq4), .divisor(cfg.pnl_h), .rem_next(yr3), .quo_next(yq3)
	);

	logic [RW-1:0]    xr_s2, yr_s2;
	logic [QW-1:0]    xq_s2, yq_s2;
	spm_pkg::colour_t col_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			xr_s2  <= xr3;
			xq_s2  <= xq3;
			yr_s2  <= yr3;
			yq_s2  <= yq3;
			col_s2 <= col_s1;
		end
	end

	// ---------------- stage 3: lower three quotient bits ----------------
	logic [RW-1:0] xr2, xr1, xr0, yr2, yr1, yr0;
	logic [QW-1:0] xq2, xq1, xq0, yq2, yq1, yq0;

	spm_div_step #(.BIT_POS(2)) u_x2 (
		.rem(xr_s2), .quo(xq_s2), .divisor(cfg.pnl_w), .rem_next(xr2), .quo_next(xq2)
	);
	spm_div_step #(.BIT_POS(1)) u_x1 (
		.rem(xr2), .quo(xq2), .divisor(cfg.pnl_w), .rem_next(xr1), .quo_next(xq1)
	);
	spm_div_step #(.BIT_POS(0)) u_x0 (
		.rem(xr1), .quo(xq1), .divisor(cfg.pnl_w), .rem_next(xr0), .quo_next(xq0)
	);
	spm_div_step #(.BIT_POS(2)) u_y2 (
		.rem(yr_s2), .quo(yq_s2), .divisor(cfg.pnl_h), .rem_next(yr2), .quo_next(yq2)
	);
	spm_div_step #(.BIT_POS(1)) u_y1 (
		.rem(yr2), .quo(yq2), .divisor(cfg.pnl_h), .rem_next(yr1), .quo_next(yq1)
	);
	spm_div_step #(.BIT_POS(0)) u_y0 (
		.rem(yr1), .quo(yq1), .divisor(cfg.pnl_h), .rem_next(yr0), .quo_next(yq0)
	);

	// remainders are below the 8-bit divisors
	logic [7:0]       px_s3, py_s3;
	logic [QW-1:0]    pcol_s3, prow_s3;
	spm_pkg::colour_t col_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			px_s3   <= xr0[7:0];
			py_s3   <= yr0[7:0];
			pcol_s3 <= xq0;
			prow_s3 <= yq0;
			col_s3  <= col_s2;
		end
	end

	// ---------------- stage 4: serpentine order and panel rotation ----------------
	logic          odd_row;
	logic [OW-1:0] row_base;
	logic [QW-1:0] col_in_row;
	logic [OW-1:0] order_d;
	logic [7:0]    px_d, py_d;

	assign odd_row    = prow_s3[0];
	// at most 30 * 31 + 30, inside ten bits
	assign row_base   = OW'(prow_s3 * cfg.panels_per_row);
	// odd rows run right to left; the column index is always below panels_per_row
	assign col_in_row = odd_row ? (cfg.panels_per_row - 5'd1 - pcol_s3) : pcol_s3;
	assign order_d    = row_base + OW'(col_in_row);
	// odd rows hold panels turned half a turn
	assign px_d       = odd_row ? (cfg.pnl_w - 8'd1 - px_s3) : px_s3;
	assign py_d       = odd_row ? (cfg.pnl_h - 8'd1 - py_s3) : py_s3;

	logic [OW-1:0]    order_s4;
	logic [7:0]       px_s4, py_s4;
	spm_pkg::colour_t col_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && valid_s3) begin
			order_s4 <= order_d;
			px_s4    <= px_d;
			py_s4    <= py_d;
			col_s4   <= col_s3;
		end
	end

	// ---------------- stage 5: chain column, output register ----------------
	logic [14:0] chain_x_d;

	// wraps to 15 bits, reachable once pnl_w times the panel count exceeds 32768
	assign chain_x_d = 15'(cfg.pnl_w * order_s4) + 15'(px_s4);

	spm_pkg::chain_t chain_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv_s5) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s5 && valid_s4) begin
			chain_s5.chain_x   <= chain_x_d;
			chain_s5.chain_y   <= py_s4[6:0];
			chain_s5.red_out   <= col_s4.red;
			chain_s5.green_out <= col_s4.green;
			chain_s5.blue_out  <= col_s4.blue;
		end
	end

	assign chain_valid = valid_s5;
	assign chain       = chain_s5;

endmodule

`default_nettype wire
